FILE: rtl/rgbaob_pkg.sv
// Shared types and constants for the RGBA8 source-over blender.
`default_nettype none

package rgbaob_pkg;

  // Pixel layout: red 7:0, green 15:8, blue 23:16, alpha 31:24
  localparam int unsigned PixW   = 32;
  localparam int unsigned ChW    = 8;
  localparam int unsigned NColor = 3;
  localparam int unsigned ColorW = NColor * ChW;

  // Weighted channel sum sc*sa + dc*wd stays below 2^17
  localparam int unsigned NumW = 17;
  // Divisor aligned to the top quotient bit: oa << (ChW - 1)
  localparam int unsigned DsrW = 2 * ChW - 1;

  // Quotient bits resolved per divider stage, and number of stages
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned NDivStages    = ChW / StepsPerStage;

  localparam logic [ChW-1:0] ChMax = 8'hff;

  typedef logic [ChW-1:0] chan_t;

  // One word in flight through the divider stages
  typedef struct packed {
    logic                          valid;
    logic                          zero;
    chan_t                         oa;
    logic [DsrW-1:0]               dsr;
    logic [NColor-1:0][NumW-1:0]   rem;
    logic [NColor-1:0][ChW-1:0]    quo;
  } div_t;

endpackage

`default_nettype wire

FILE: rtl/rgbaob_if.sv
// Handshake channels for the blender: input pixel pair and blended result.
`default_nettype none

interface rgbaob_in_if;
  import rgbaob_pkg::*;

  logic            valid;
  logic            ready;
  logic            mode;
  logic [PixW-1:0] dest_pixel;
  logic [PixW-1:0] src_pixel;
  logic [ChW-1:0]  explicit_alpha;

  modport source (
    output valid, mode, dest_pixel, src_pixel, explicit_alpha,
    input  ready
  );
  modport sink (
    input  valid, mode, dest_pixel, src_pixel, explicit_alpha,
    output ready
  );
endinterface

interface rgbaob_out_if;
  import rgbaob_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] blended_pixel;

  modport source (
    output valid, blended_pixel,
    input  ready
  );
  modport sink (
    input  valid, blended_pixel,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/rgbaob_div_stage.sv
// One divider stage: resolves two quotient bits of each color channel.
`default_nettype none

module rgbaob_div_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire rgbaob_pkg::div_t   div_i,
  output rgbaob_pkg::div_t        div_o
);
  import rgbaob_pkg::*;

  div_t             div_d;
  div_t             div_q;
  logic             vld_q;
  logic [DsrW-1:0]  dsr;
  logic [NColor-1:0][NumW-1:0] rem;
  logic [NColor-1:0][ChW-1:0]  quo;

  // Restoring division steps; divisor shifts down one bit per step
  always_comb begin
    dsr = div_i.dsr;
    rem = div_i.rem;
    quo = div_i.quo;
    for (int s = 0; s < int'(StepsPerStage); s++) begin
      for (int c = 0; c < int'(NColor); c++) begin
        if (NumW'(dsr) <= rem[c]) begin
          rem[c] = rem[c] - NumW'(dsr);
          quo[c] = {quo[c][ChW-2:0], 1'b1};
        end else begin
          quo[c] = {quo[c][ChW-2:0], 1'b0};
        end
      end
      dsr = dsr >> 1;
    end
    div_d       = div_i;
    div_d.dsr   = dsr;
    div_d.rem   = rem;
    div_d.quo   = quo;
  end

  // Valid bit travels with the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= div_i.valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  always_comb begin
    div_o       = div_q;
    div_o.valid = vld_q;
  end

endmodule

`default_nettype wire

FILE: rtl/rgba8_alpha_over_blend.sv
// Top level: pipelined source-over compositing of straight-alpha RGBA8 pixels.
//
//   Port    Dir  Fields                                          Word accepted when
//   pix_i   in   mode, dest_pixel, src_pixel, explicit_alpha     pix_i.valid & pix_i.ready
//   pix_o   out  blended_pixel                                   pix_o.valid & pix_o.ready
//
// One pixel per clock over six register stages: weight multiply, channel sums, then
// four divider stages of two quotient bits each; the last divider stage is the output.
// An accepted word passes stages 1 and 2 and each divider stage before pix_o offers it.
// Reset clears only the valid bits; the pipeline is empty afterwards.
// A stall at pix_o freezes every stage at once; pix_i.ready drops only while the
// output holds a word that is not taken, so no word is lost or repeated.
`default_nettype none

module rgba8_alpha_over_blend (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rgbaob_in_if.sink   pix_i,
  rgbaob_out_if.source pix_o
);
  import rgbaob_pkg::*;

  logic ce;

  // Stage 1: source alpha and weighted destination alpha
  chan_t            sa_d;
  logic [2*ChW-1:0] wd_prod;
  logic             s1_vld_q;
  chan_t            s1_sa_q;
  chan_t            s1_wd_q;
  logic [ColorW-1:0] s1_src_q;
  logic [ColorW-1:0] s1_dst_q;

  // Stage 2: output alpha and weighted channel sums
  chan_t            oa;
  div_t             s2_d;
  div_t             s2_q;
  logic             s2_vld_q;

  div_t             stg [NDivStages+1];

  // Advance all stages unless the output word is stalled
  assign ce          = !stg[NDivStages].valid || pix_o.ready;
  assign pix_i.ready = ce;

  assign sa_d    = pix_i.mode ? pix_i.explicit_alpha : pix_i.src_pixel[PixW-1 -: ChW];
  assign wd_prod = (2*ChW)'(pix_i.dest_pixel[PixW-1 -: ChW]) * (2*ChW)'(ChMax - sa_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (ce) begin
      s1_vld_q <= pix_i.valid;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      s1_sa_q  <= sa_d;
      s1_wd_q  <= wd_prod[2*ChW-1 -: ChW];
      s1_src_q <= pix_i.src_pixel[ColorW-1:0];
      s1_dst_q <= pix_i.dest_pixel[ColorW-1:0];
      s2_q     <= s2_d;
    end
  end

  // Output alpha never exceeds 255; sums feed the divider
  assign oa = s1_sa_q + s1_wd_q;

  always_comb begin
    s2_d       = '0;
    s2_d.valid = s1_vld_q;
    s2_d.zero  = (oa == '0);
    s2_d.oa    = oa;
    s2_d.dsr   = {oa, {(ChW-1){1'b0}}};
    for (int c = 0; c < int'(NColor); c++) begin
      s2_d.rem[c] =
        NumW'((2*ChW)'(s1_src_q[c*ChW +: ChW]) * (2*ChW)'(s1_sa_q)) +
        NumW'((2*ChW)'(s1_dst_q[c*ChW +: ChW]) * (2*ChW)'(s1_wd_q));
    end
  end

  always_comb begin
    stg[0]       = s2_q;
    stg[0].valid = s2_vld_q;
  end

  // Divider stages
  for (genvar g = 0; g < int'(NDivStages); g++) begin : g_div
    rgbaob_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (ce),
      .div_i  (stg[g]),
      .div_o  (stg[g+1])
    );
  end

  // Drive the result; zero alpha gives an all-zero pixel
  assign pix_o.valid         = stg[NDivStages].valid;
  assign pix_o.blended_pixel = stg[NDivStages].zero ? '0 :
                               {stg[NDivStages].oa, stg[NDivStages].quo[2],
                                stg[NDivStages].quo[1], stg[NDivStages].quo[0]};

endmodule

`default_nettype wire

FILE: rtl/rgbaob_chk.sv
// Port-level checks on the blender, bound to the top level.
`default_nettype none

module rgbaob_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] blended_pixel_i
);

  // A stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(blended_pixel_i))
    else $error("stalled result word changed or vanished");

  // Zero output alpha means an all-zero pixel
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (blended_pixel_i[31:24] == 8'h00) |-> (blended_pixel_i == 32'h0))
    else $error("nonzero color with zero alpha");

  // Input is never blocked unless the output holds an untaken word
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled without output backpressure");

  // No result word in the first cycle out of reset
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result word right after reset");

endmodule

bind rgba8_alpha_over_blend rgbaob_chk u_rgbaob_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (pix_i.valid),
  .in_ready_i      (pix_i.ready),
  .out_valid_i     (pix_o.valid),
  .out_ready_i     (pix_o.ready),
  .blended_pixel_i (pix_o.blended_pixel)
);

`default_nettype wire
